### design/fwtt_pkg.sv
package fwtt_pkg;

  // register file of the configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PARENT_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;

  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned PAY_W     = 32;
  localparam int unsigned NOW_W     = 31;
  localparam int unsigned DL_W      = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned REM_W     = 16;
  localparam int unsigned EV_W      = 3;

  localparam logic [ADDR_W-1:0]    PARENT_ID_RST     = 8'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

  localparam int unsigned DEF_ENTRIES = 5;

  // stream widths
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 56;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EV_W-1:0] EV_STORED    = 3'd1;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd2;
  localparam logic [EV_W-1:0] EV_CONFIRMED = 3'd3;
  localparam logic [EV_W-1:0] EV_LATE      = 3'd4;
  localparam logic [EV_W-1:0] EV_TIMEOUT   = 3'd5;
  localparam logic [EV_W-1:0] EV_WAITING   = 3'd6;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_CONF,
    ST_TICK,
    ST_FLUSH
  } state_t;

endpackage

### design/forward_watch_timeout_table.sv
// Forward watch timeout table: tracks messages sent to the parent node and checks that the
// parent forwards each one before its deadline (now + timeout_ticks). A message to the parent
// takes the first free slot, a message from the parent confirms the first valid slot with the
// same payload (or reports it late if its deadline has passed), and a clock tick (in_tuser = 1)
// reports every valid slot as timed out or waiting. Each request yields one or more results;
// out_tlast marks the final one, and a request that causes no event yields a single "none"
// result. One request is handled at a time: a small sequencer walks the slots one per cycle,
// unless the result side stalls, through a single shared 33-bit adder (deadline computation
// and deadline compares). Configuration is written through cfg_wen / cfg_index / cfg_wdata
// (0 parent_id, 1 timeout_ticks); the user must write it only while the block is idle, as the
// block itself does not enforce this.
module forward_watch_timeout_table #(
  parameter int unsigned ENTRIES = fwtt_pkg::DEF_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              cfg_wen,
  input  logic [fwtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwtt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: msg_from[7:0], msg_to[15:8], payload[47:16], now[78:48], zero fill[79]
  input  logic [fwtt_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: mode[0]
  input  logic                              in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: slot[3:0], event_payload[35:4], remaining[51:36], zero fill[55:52]
  output logic [fwtt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // tuser: event_res[2:0]
  output logic [fwtt_pkg::EV_W-1:0]         out_tuser,
  output logic                              out_tlast
);
  import fwtt_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // configuration registers
  logic [ADDR_W-1:0]    parent_id_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  // slot table
  logic [ENTRIES-1:0]   slot_valid_r;
  logic [PAY_W-1:0]     slot_pay_r [ENTRIES];
  logic [DL_W-1:0]      slot_dl_r  [ENTRIES];

  // latched request
  logic [PAY_W-1:0]     pay_r;
  logic [NOW_W-1:0]     now_r;
  logic                 from_par_r;

  // sequencer
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  // pending result, held until the next one shows whether it is last
  logic                 pend_valid_r, pend_valid_nxt;
  logic [EV_W-1:0]      pend_ev_r;
  logic [SLOT_W-1:0]    pend_slot_r;
  logic [PAY_W-1:0]     pend_pay_r;
  logic [REM_W-1:0]     pend_rem_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]      out_ev_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [PAY_W-1:0]     out_pay_r;
  logic [REM_W-1:0]     out_rem_r;
  logic                 out_last_r;

  // request fields
  logic [ADDR_W-1:0]    in_from, in_to;
  logic [PAY_W-1:0]     in_pay;
  logic [NOW_W-1:0]     in_now;
  logic                 in_acc;

  // current slot
  logic                 cur_valid;
  logic [PAY_W-1:0]     cur_pay;
  logic [DL_W-1:0]      cur_dl;

  // shared adder
  logic [DL_W:0]        op_a, op_b, sum;
  logic                 cin;
  logic                 dl_lt_now, dl_eq_now;
  logic [REM_W-1:0]     rem_sat;

  // step results
  logic                 res_valid;
  logic [EV_W-1:0]      res_ev;
  logic [SLOT_W-1:0]    res_slot;
  logic [PAY_W-1:0]     res_pay;
  logic [REM_W-1:0]     res_rem;
  logic                 wr_store, wr_clear, done;
  logic                 can_emit, stall, flush_go, push_out;
  logic [EV_W-1:0]      push_ev;
  logic [SLOT_W-1:0]    push_slot;
  logic [PAY_W-1:0]     push_pay;
  logic [REM_W-1:0]     push_rem;
  logic                 push_last;

  assign in_from = in_tdata[7:0];
  assign in_to   = in_tdata[15:8];
  assign in_pay  = in_tdata[47:16];
  assign in_now  = in_tdata[78:48];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign cur_valid = slot_valid_r[idx_r];
  assign cur_pay   = slot_pay_r[idx_r];
  assign cur_dl    = slot_dl_r[idx_r];

  // shared adder: now + timeout on store, deadline - now otherwise
  always_comb begin
    if (state_r == ST_STORE) begin
      op_a = {2'b00, now_r};
      op_b = {17'd0, timeout_r};
      cin  = 1'b0;
    end else begin
      op_a = {1'b0, cur_dl};
      op_b = ~{2'b00, now_r};
      cin  = 1'b1;
    end
    sum = op_a + op_b + {{DL_W{1'b0}}, cin};
  end

  assign dl_lt_now = sum[DL_W];
  assign dl_eq_now = (sum == '0);
  assign rem_sat   = (sum[DL_W-1:REM_W] != '0) ? {REM_W{1'b1}} : sum[REM_W-1:0];

  assign can_emit = !out_valid_r || out_tready;

  // one scan step on the current slot
  always_comb begin
    res_valid = 1'b0;
    res_ev    = EV_NONE;
    res_slot  = SLOT_W'(idx_r);
    res_pay   = pay_r;
    res_rem   = '0;
    wr_store  = 1'b0;
    wr_clear  = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      ST_STORE: begin
        if (!cur_valid) begin
          res_valid = 1'b1;
          res_ev    = EV_STORED;
          wr_store  = 1'b1;
          done      = 1'b1;
        end else if (idx_r == LAST_IDX) begin
          res_valid = 1'b1;
          res_ev    = EV_FULL;
          res_slot  = '0;
          done      = 1'b1;
        end
      end
      ST_CONF: begin
        if (cur_valid && (cur_pay == pay_r)) begin
          res_valid = 1'b1;
          done      = 1'b1;
          if (dl_lt_now) begin
            res_ev = EV_LATE;
          end else begin
            res_ev   = EV_CONFIRMED;
            wr_clear = 1'b1;
          end
        end else if (idx_r == LAST_IDX) begin
          done = 1'b1;
        end
      end
      ST_TICK: begin
        done = (idx_r == LAST_IDX);
        if (cur_valid) begin
          res_valid = 1'b1;
          res_pay   = cur_pay;
          if (dl_lt_now || dl_eq_now) begin
            res_ev   = EV_TIMEOUT;
            wr_clear = 1'b1;
          end else begin
            res_ev  = EV_WAITING;
            res_rem = rem_sat;
          end
        end
      end
      ST_IDLE, ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  // result hand-off: pending result moves out when a newer one arrives or at the end
  always_comb begin
    stall     = res_valid && pend_valid_r && !can_emit;
    flush_go  = (state_r == ST_FLUSH) && can_emit;
    push_out  = (res_valid && pend_valid_r && !stall) || flush_go;
    push_ev   = pend_ev_r;
    push_slot = pend_slot_r;
    push_pay  = pend_pay_r;
    push_rem  = pend_rem_r;
    push_last = flush_go;
    if (flush_go && !pend_valid_r) begin
      push_ev   = EV_NONE;
      push_slot = '0;
      push_pay  = '0;
      push_rem  = '0;
    end
    pend_valid_nxt = pend_valid_r;
    if (res_valid && !stall) begin
      pend_valid_nxt = 1'b1;
    end else if (flush_go) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && !out_tready;
    if (push_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            state_nxt = ST_TICK;
          end else if (in_to == parent_id_r) begin
            state_nxt = ST_STORE;
          end else if (in_from == parent_id_r) begin
            state_nxt = ST_CONF;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_STORE: begin
        if (!stall && done) begin
          state_nxt = from_par_r ? ST_CONF : ST_FLUSH;
        end
      end
      ST_CONF, ST_TICK: begin
        if (!stall && done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // slot pointer
  always_comb begin
    idx_nxt = '0;
    if ((state_nxt == state_r) &&
        ((state_r == ST_STORE) || (state_r == ST_CONF) || (state_r == ST_TICK))) begin
      idx_nxt = stall ? idx_r : idx_r + IDX_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      parent_id_r  <= PARENT_ID_RST;
      timeout_r    <= TIMEOUT_TICKS_RST;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (!stall && wr_store) begin
        slot_valid_r[idx_r] <= 1'b1;
      end else if (!stall && wr_clear) begin
        slot_valid_r[idx_r] <= 1'b0;
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_PARENT_ID:     parent_id_r <= cfg_wdata[ADDR_W-1:0];
          REG_TIMEOUT_TICKS: timeout_r   <= cfg_wdata[TIMEOUT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pay_r      <= in_pay;
      now_r      <= in_now;
      from_par_r <= (in_from == parent_id_r);
    end
    if (!stall && wr_store) begin
      slot_pay_r[idx_r] <= pay_r;
      slot_dl_r[idx_r]  <= sum[DL_W-1:0];
    end
    if (res_valid && !stall) begin
      pend_ev_r   <= res_ev;
      pend_slot_r <= res_slot;
      pend_pay_r  <= res_pay;
      pend_rem_r  <= res_rem;
    end
    if (push_out) begin
      out_ev_r   <= push_ev;
      out_slot_r <= push_slot;
      out_pay_r  <= push_pay;
      out_rem_r  <= push_rem;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rem_r, out_pay_r, out_slot_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

endmodule

### verif/forward_watch_timeout_table_tb.sv
module forward_watch_timeout_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwtt_pkg::*;

  localparam int SLOTS = DEF_ENTRIES;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 6;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 92;
  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [31:0] pay;
    logic [30:0] now_ms;
  } request_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  slot;
    logic [31:0] pay;
    logic [15:0] rem;
    logic        last;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [EV_W-1:0] out_tuser;
  logic out_tlast;

  forward_watch_timeout_table #(.ENTRIES(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the watch table and its registers
  logic [7:0]  cur_parent;
  logic [15:0] cur_timeout;
  logic        slot_busy [SLOTS];
  logic [31:0] slot_pay  [SLOTS];
  logic [31:0] slot_due  [SLOTS];

  result_t pending_events[$];
  directed_row_t directed_rows[$];
  logic [31:0] pay_pool[8];
  int unsigned cur_ms;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // work out the events of one accepted request and queue them
  task automatic predict_events(input request_t r, input bit typed, input result_t typed_res);
    result_t res[$];
    int hit;
    logic [31:0] now32;
    logic [31:0] left;
    now32 = {1'b0, r.now_ms};
    if (!r.mode) begin
      // store into the first free slot
      if (r.dst == cur_parent) begin
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && !slot_busy[i]) hit = i;
        if (hit >= 0) begin
          slot_busy[hit] = 1'b1;
          slot_pay[hit]  = r.pay;
          slot_due[hit]  = now32 + {16'd0, cur_timeout};
          res.push_back('{EV_STORED, 4'(hit), r.pay, 16'd0, 1'b0});
        end else begin
          res.push_back('{EV_FULL, 4'd0, r.pay, 16'd0, 1'b0});
        end
      end
      // confirm the first valid slot with the same payload
      if (r.src == cur_parent) begin
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && slot_busy[i] && slot_pay[i] == r.pay) hit = i;
        if (hit >= 0) begin
          if (slot_due[hit] < now32) begin
            res.push_back('{EV_LATE, 4'(hit), r.pay, 16'd0, 1'b0});
          end else begin
            slot_busy[hit] = 1'b0;
            slot_pay[hit]  = '0;
            slot_due[hit]  = '0;
            res.push_back('{EV_CONFIRMED, 4'(hit), r.pay, 16'd0, 1'b0});
          end
        end
      end
    end else begin
      // tick: expire or report time left, slot by slot
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i]) begin
          if (slot_due[i] <= now32) begin
            res.push_back('{EV_TIMEOUT, 4'(i), slot_pay[i], 16'd0, 1'b0});
            slot_busy[i] = 1'b0;
            slot_pay[i]  = '0;
            slot_due[i]  = '0;
          end else begin
            left = slot_due[i] - now32;
            if (left > 32'hFFFF) left = 32'hFFFF;
            res.push_back('{EV_WAITING, 4'(i), slot_pay[i], left[15:0], 1'b0});
          end
        end
      end
    end
    if (res.size() == 0) res.push_back('{EV_NONE, 4'd0, 32'd0, 16'd0, 1'b0});
    res[res.size()-1].last = 1'b1;
    if (typed) begin
      res.delete();
      res.push_back(typed_res);
    end
    foreach (res[i]) pending_events.push_back(res[i]);
  endtask

  // register write at the next edge, shadow follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PARENT_ID:     cur_parent = data[7:0];
      REG_TIMEOUT_TICKS: cur_timeout = data;
      default: ;
    endcase
  endtask

  // one request on the input channel, with an optional idle gap ahead of it
  task automatic send_request(input request_t r, input bit typed, input result_t typed_res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {1'b0, r.now_ms, r.pay, r.dst, r.src};
    do @(posedge clk); while (!in_tready);
    predict_events(r, typed, typed_res);
  endtask

  task automatic add_row(input logic mode, input logic [7:0] src, input logic [7:0] dst,
                         input logic [31:0] pay, input logic [30:0] now_ms, input bit typed,
                         input logic [2:0] ev, input logic [3:0] slot, input logic [31:0] ev_pay);
    directed_row_t row;
    row.req   = '{mode, src, dst, pay, now_ms};
    row.typed = typed;
    row.res   = '{ev, slot, ev_pay, 16'd0, 1'b1};
    directed_rows.push_back(row);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] other_node();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == cur_parent) v = 8'($urandom_range(255));
    return v;
  endfunction

  function automatic logic [31:0] pick_payload();
    if ($urandom_range(4) == 0) return $urandom();
    return pay_pool[$urandom_range(7)];
  endfunction

  // mostly well-formed traffic around the parent, some noise
  task automatic next_request(output request_t r, output bit counted);
    int unsigned k;
    int unsigned adv;
    k = $urandom_range(99);
    if ($urandom_range(9) == 0) adv = $urandom_range(0, 2 * cur_timeout + 2);
    else adv = $urandom_range(0, cur_timeout / 4 + 2);
    cur_ms = cur_ms + adv;
    if (cur_ms > 32'h7FFF_0000) cur_ms = $urandom_range(0, 1000);
    r.mode   = 1'b0;
    r.now_ms = 31'(cur_ms);
    r.pay    = pick_payload();
    counted  = 1'b1;
    if (k < 30) begin
      r.dst = cur_parent;
      r.src = other_node();
    end else if (k < 55) begin
      r.src = cur_parent;
      r.dst = other_node();
    end else if (k < 62) begin
      r.src = cur_parent;
      r.dst = cur_parent;
    end else if (k < 85) begin
      r.mode = 1'b1;
      r.src  = 8'($urandom());
      r.dst  = 8'($urandom());
      r.pay  = $urandom();
    end else begin
      r.mode   = 1'($urandom());
      r.src    = 8'($urandom());
      r.dst    = 8'($urandom());
      r.pay    = $urandom();
      r.now_ms = 31'($urandom());
      counted  = r.mode || r.src == cur_parent || r.dst == cur_parent;
    end
  endtask

  // result side back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // compare every accepted result with the oldest expected one
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[3:0], out_tdata[35:4], out_tdata[51:36], out_tlast};
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result ev=%0d slot=%0d payload=%h remaining=%0d last=%0b",
                 $realtime, got.ev, got.slot, got.pay, got.rem, got.last);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected ev=%0d slot=%0d payload=%h remaining=%0d last=%0b",
                   $realtime, want.ev, want.slot, want.pay, want.rem, want.last);
          $display("%0t:          actual   ev=%0d slot=%0d payload=%h remaining=%0d last=%0b",
                   $realtime, got.ev, got.slot, got.pay, got.rem, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    request_t r;
    bit counted;
    int done;
    result_t no_res;
    no_res = '0;
    cur_parent  = PARENT_ID_RST;
    cur_timeout = TIMEOUT_TICKS_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_pay[i]  = '0;
      slot_due[i]  = '0;
    end

    // reset values: parent 2, timeout 1000
    add_row(1'b1, 8'd0,   8'd0,   32'h0000_0000, 31'd0,    1, EV_NONE,      4'd0, 32'h0);
    add_row(1'b0, 8'd0,   8'd255, 32'hFFFF_FFFF, 31'd0,    1, EV_NONE,      4'd0, 32'h0);
    add_row(1'b0, 8'd5,   8'd2,   32'h8000_0000, 31'd0,    1, EV_STORED,    4'd0, 32'h8000_0000);
    add_row(1'b0, 8'd5,   8'd2,   32'h7FFF_FFFF, 31'd10,   0, EV_NONE,      4'd0, 32'h0);
    add_row(1'b0, 8'd5,   8'd2,   32'hFFFF_FFFF, 31'd20,   0, EV_NONE,      4'd0, 32'h0);
    add_row(1'b0, 8'd5,   8'd2,   32'h0000_0000, 31'd30,   0, EV_NONE,      4'd0, 32'h0);
    add_row(1'b0, 8'd5,   8'd2,   32'h1234_5678, 31'd40,   0, EV_NONE,      4'd0, 32'h0);
    // table full
    add_row(1'b0, 8'd5,   8'd2,   32'h0000_0055, 31'd50,   1, EV_FULL,      4'd0, 32'h55);
    // from the parent, payload in no slot
    add_row(1'b0, 8'd2,   8'd7,   32'h0000_DEAD, 31'd60,   1, EV_NONE,      4'd0, 32'h0);
    // confirmation exactly at the deadline is in time
    add_row(1'b0, 8'd2,   8'd7,   32'h7FFF_FFFF, 31'd1010, 1, EV_CONFIRMED, 4'd1, 32'h7FFF_FFFF);
    // to and from the parent: stored then confirmed at once
    add_row(1'b0, 8'd2,   8'd2,   32'hA5A5_A5A5, 31'd1020, 0, EV_NONE,      4'd0, 32'h0);
    // confirmation after the deadline stays in the table
    add_row(1'b0, 8'd2,   8'd9,   32'h8000_0000, 31'd1001, 1, EV_LATE,      4'd0, 32'h8000_0000);
    add_row(1'b1, 8'd0,   8'd0,   32'h0,         31'd500,  0, EV_NONE,      4'd0, 32'h0);
    // tick at a deadline expires the slot
    add_row(1'b1, 8'd0,   8'd0,   32'h0,         31'd1020, 0, EV_NONE,      4'd0, 32'h0);
    add_row(1'b0, 8'd255, 8'd2,   32'h0F0F_0F0F, 31'h7FFF_FFFF, 0, EV_NONE, 4'd0, 32'h0);
    // time runs backwards: remaining saturates
    add_row(1'b1, 8'd0,   8'd0,   32'h0,         31'd0,    0, EV_NONE,      4'd0, 32'h0);
    add_row(1'b1, 8'd0,   8'd0,   32'h0,         31'h7FFF_FFFF, 0, EV_NONE, 4'd0, 32'h0);
    add_row(1'b1, 8'd255, 8'd255, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, EV_NONE, 4'd0, 32'h0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < 4; p++) begin
      drain_and_settle();
      case (p)
        0: begin
          write_reg(REG_PARENT_ID, 16'd0);
          write_reg(REG_TIMEOUT_TICKS, 16'd0);
          write_reg(REG_SPARE_2, 16'($urandom()));
          write_reg(REG_SPARE_3, 16'($urandom()));
          send_idle_pct = 0;
          recv_stall_pct = 0;
          cur_ms = 0;
        end
        1: begin
          write_reg(REG_PARENT_ID, 16'hFFFF);
          write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
          send_idle_pct = 82;
          recv_stall_pct = 0;
          cur_ms = 32'h7FFE_0000;
        end
        2: begin
          write_reg(REG_PARENT_ID, 16'($urandom()));
          write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 300)));
          send_idle_pct = 0;
          recv_stall_pct = 82;
          cur_ms = $urandom_range(0, 32'h4000_0000);
        end
        default: begin
          write_reg(REG_PARENT_ID, 16'(PARENT_ID_RST));
          write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(50, 5000)));
          send_idle_pct = 12;
          recv_stall_pct = 12;
          cur_ms = $urandom_range(0, 100000);
        end
      endcase
      cfg_wen <= 1'b0;
      foreach (pay_pool[i]) pay_pool[i] = $urandom();
      done = 0;
      while (done < PHASE_REQUESTS) begin
        next_request(r, counted);
        send_request(r, 1'b0, no_res);
        if (counted) done++;
      end
    end

    drain_and_settle();
    if (errors == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### forward_watch_timeout_table.f
design/fwtt_pkg.sv
design/forward_watch_timeout_table.sv
verif/forward_watch_timeout_table_tb.sv
